@@ sv/lkc_pkg.sv @@
// ---------------------------------------------------------------------------
// lkc_pkg
// Shared sizes, codes and structures of the keyed slot cache.
// ---------------------------------------------------------------------------
package lkc_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

    localparam int KEY_W       = 64;
    localparam int ROWS_W      = 16;
    localparam int STAMP_W     = 64;
    localparam int TOT_W       = 32;
    localparam int SLOT_OUT_W  = 6;
    localparam int OCC_OUT_W   = 7;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 96;

    localparam logic [ROWS_W-1:0] ROW_LIMIT_RESET = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX         = '1;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   tag_high;
        logic [KEY_W-1:0]   tag_low;
        logic [ROWS_W-1:0]  rows;
        logic [STAMP_W-1:0] stamp;
    } slot_entry_t;

    typedef struct packed {
        logic              key_en;
        logic              stamp_en;
        logic [IDX_W-1:0]  addr;
        slot_entry_t       data;
    } slot_write_t;

    typedef struct packed {
        logic              start;
        logic              step;
        logic [IDX_W-1:0]  idx;
        logic              occ;
    } scan_ctrl_t;

    typedef struct packed {
        logic              match;
        logic [IDX_W-1:0]  match_idx;
        logic [ROWS_W-1:0] match_rows;
        logic [IDX_W-1:0]  victim_idx;
    } scan_result_t;

endpackage

@@ sv/lkc_slot_store.sv @@
// ---------------------------------------------------------------------------
// lkc_slot_store
// Slot memory holding key halves, row count and use stamp of every slot.
// ---------------------------------------------------------------------------
module lkc_slot_store
    import lkc_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output slot_entry_t      rd_data,
    input  slot_write_t      wr
);

    logic [KEY_W-1:0]   tag_high_mem [SLOT_COUNT];
    logic [KEY_W-1:0]   tag_low_mem  [SLOT_COUNT];
    logic [ROWS_W-1:0]  rows_mem     [SLOT_COUNT];
    logic [STAMP_W-1:0] stamp_mem    [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            tag_high_mem[wr.addr] <= wr.data.tag_high;
            tag_low_mem[wr.addr]  <= wr.data.tag_low;
            rows_mem[wr.addr]     <= wr.data.rows;
        end
        if (wr.stamp_en)
        begin
            stamp_mem[wr.addr] <= wr.data.stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data.tag_high <= tag_high_mem[rd_addr];
            rd_data.tag_low  <= tag_low_mem[rd_addr];
            rd_data.rows     <= rows_mem[rd_addr];
            rd_data.stamp    <= stamp_mem[rd_addr];
        end
    end

endmodule

@@ sv/lkc_scan_unit.sv @@
// ---------------------------------------------------------------------------
// lkc_scan_unit
// Shared key and stamp comparator, fed one slot per cycle during a scan.
// ---------------------------------------------------------------------------
module lkc_scan_unit
    import lkc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  slot_entry_t      entry,
    input  logic [KEY_W-1:0] key_high,
    input  logic [KEY_W-1:0] key_low,
    output scan_result_t     result
);

    logic               match_reg,      match_next;
    logic [IDX_W-1:0]   match_idx_reg,  match_idx_next;
    logic [ROWS_W-1:0]  match_rows_reg, match_rows_next;
    logic [IDX_W-1:0]   best_idx_reg,   best_idx_next;
    logic               best_occ_reg,   best_occ_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;

    logic key_eq;
    logic take;

    always_comb
    begin
        key_eq = ctrl.occ && (entry.tag_high == key_high) && (entry.tag_low == key_low);

        // Empty slots rank first, then the older stamp; ties keep the lower index.
        if (ctrl.idx == '0)
        begin
            take = 1'b1;
        end
        else if (ctrl.occ != best_occ_reg)
        begin
            take = !ctrl.occ;
        end
        else
        begin
            take = ctrl.occ && (entry.stamp < best_stamp_reg);
        end

        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_rows_next = match_rows_reg;
        best_idx_next   = best_idx_reg;
        best_occ_next   = best_occ_reg;
        best_stamp_next = best_stamp_reg;

        if (ctrl.start)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (!match_reg && key_eq)
            begin
                match_next      = 1'b1;
                match_idx_next  = ctrl.idx;
                match_rows_next = entry.rows;
            end
            if (take)
            begin
                best_idx_next   = ctrl.idx;
                best_occ_next   = ctrl.occ;
                best_stamp_next = entry.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg  <= match_idx_next;
        match_rows_reg <= match_rows_next;
        best_idx_reg   <= best_idx_next;
        best_occ_reg   <= best_occ_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign result.match      = match_reg;
    assign result.match_idx  = match_idx_reg;
    assign result.match_rows = match_rows_reg;
    assign result.victim_idx = best_idx_reg;

endmodule

@@ sv/lru_keyed_slot_cache.sv @@
// ---------------------------------------------------------------------------
// lru_keyed_slot_cache
// Tag and LRU replacement logic of a fully associative cache of keyed slots.
// ---------------------------------------------------------------------------
// A lookup or an accepted insert passes through the idle state, in which the
// transaction is taken in, then the scan state, which reads one slot per cycle
// because the slot memory has one read port and the scan goes through a
// single key and stamp comparator, and waits out the registered read of
// the last slot; the update state follows. A new transaction is taken only
// in the idle state. An insert whose row count is zero or above row_limit
// skips the scan. A finished result sits in the output register while the
// next transaction is taken in; the update only waits if that register is
// still full. row_limit is to be written through cfg_we/cfg_wdata only while
// the block is idle (the block does not enforce this) and resets to 65535.
module lru_keyed_slot_cache
    import lkc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [ROWS_W-1:0]      cfg_wdata,      // row_limit
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,        // key_high, key_low, row_count
    input  logic [0:0]             s_tuser,        // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata         // hit, accepted, slot_index,
                                                   // rows_held, occupied,
                                                   // hit_total, miss_total, pad
);

    state_t               state_reg, state_next;
    logic [ROWS_W-1:0]    row_limit_reg;
    opcode_t              op_reg;
    logic [KEY_W-1:0]     key_high_reg;
    logic [KEY_W-1:0]     key_low_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic                 ins_ok_reg;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_occ_reg;
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [CNT_W-1:0]     occ_cnt_reg;
    logic [STAMP_W-1:0]   use_clock_reg;
    logic [TOT_W-1:0]     hits_reg;
    logic [TOT_W-1:0]     misses_reg;
    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                 in_fire;
    opcode_t              in_op;
    logic [KEY_W-1:0]     in_key_high;
    logic [KEY_W-1:0]     in_key_low;
    logic [ROWS_W-1:0]    in_rows;
    logic                 in_ins_ok;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    slot_entry_t          rd_data;
    slot_write_t          wr;
    scan_ctrl_t           scan_ctrl;
    scan_result_t         res;

    logic                 commit;
    logic                 do_hit;
    logic                 do_miss;
    logic                 do_ins;
    logic [IDX_W-1:0]     wr_idx;
    logic                 new_slot;
    logic [STAMP_W-1:0]   stamp_next;
    logic [TOT_W-1:0]     hits_next;
    logic [TOT_W-1:0]     misses_next;
    logic [CNT_W-1:0]     occ_cnt_next;
    logic                 res_hit;
    logic                 res_acc;
    logic [IDX_W-1:0]     res_idx;
    logic [ROWS_W-1:0]    res_rows;

    assign in_op       = opcode_t'(s_tuser[0]);
    assign in_key_high = s_tdata[KEY_W-1:0];
    assign in_key_low  = s_tdata[2*KEY_W-1:KEY_W];
    assign in_rows     = s_tdata[2*KEY_W+ROWS_W-1:2*KEY_W];
    assign in_ins_ok   = (in_rows != '0) && (in_rows <= row_limit_reg);
    assign in_fire     = s_tvalid && s_tready;

    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        rd_en         = 1'b0;
        commit        = 1'b0;
        scan_cnt_next = scan_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                scan_cnt_next = '0;
                if (s_tvalid)
                begin
                    if (in_op == OP_LOOKUP || in_ins_ok)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg < CNT_W'(SLOT_COUNT))
                begin
                    rd_en         = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    // The last slot is compared in this cycle.
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        do_hit       = (op_reg == OP_LOOKUP) && res.match;
        do_miss      = (op_reg == OP_LOOKUP) && !res.match;
        do_ins       = (op_reg == OP_INSERT) && ins_ok_reg;
        wr_idx       = res.match ? res.match_idx : res.victim_idx;
        new_slot     = do_ins && !slot_valid_reg[wr_idx];
        stamp_next   = use_clock_reg + 1'b1;
        hits_next    = (do_hit && hits_reg != TOT_MAX) ? hits_reg + 1'b1 : hits_reg;
        misses_next  = (do_miss && misses_reg != TOT_MAX) ? misses_reg + 1'b1 : misses_reg;
        occ_cnt_next = new_slot ? occ_cnt_reg + 1'b1 : occ_cnt_reg;

        res_hit  = do_hit;
        res_acc  = do_ins;
        res_idx  = (do_hit || do_ins) ? wr_idx : '0;
        res_rows = do_hit ? res.match_rows : '0;

        wr.key_en        = commit && do_ins;
        wr.stamp_en      = commit && (do_hit || do_ins);
        wr.addr          = wr_idx;
        wr.data.tag_high = key_high_reg;
        wr.data.tag_low  = key_low_reg;
        wr.data.rows     = rows_reg;
        wr.data.stamp    = stamp_next;

        scan_ctrl.start = in_fire;
        scan_ctrl.step  = rd_valid_reg;
        scan_ctrl.idx   = rd_idx_reg;
        scan_ctrl.occ   = rd_occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_limit_reg  <= ROW_LIMIT_RESET;
            scan_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            slot_valid_reg <= '0;
            occ_cnt_reg    <= '0;
            use_clock_reg  <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_valid_reg <= rd_en;
            if (cfg_we)
            begin
                row_limit_reg <= cfg_wdata;
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
                hits_reg     <= hits_next;
                misses_reg   <= misses_next;
                occ_cnt_reg  <= occ_cnt_next;
                if (do_hit || do_ins)
                begin
                    use_clock_reg <= stamp_next;
                end
                if (do_ins)
                begin
                    slot_valid_reg[wr_idx] <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= in_op;
            key_high_reg <= in_key_high;
            key_low_reg  <= in_key_low;
            rows_reg     <= in_rows;
            ins_ok_reg   <= in_ins_ok;
        end
        rd_idx_reg <= rd_addr;
        rd_occ_reg <= slot_valid_reg[rd_addr];
        if (commit)
        begin
            m_tdata_reg <= OUT_TDATA_W'({misses_next, hits_next,
                                         OCC_OUT_W'(occ_cnt_next), res_rows,
                                         SLOT_OUT_W'(res_idx), res_acc, res_hit});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lkc_slot_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    lkc_scan_unit u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .entry    (rd_data),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .result   (res)
    );

    // The running occupancy count must track the slot valid bits.
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        occ_cnt_reg == CNT_W'($countones(slot_valid_reg)))
        else $error("occupancy count out of step with slot valid bits");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(SLOT_COUNT))
        else $error("scan counter ran past the last slot");

    // A result never reports both a lookup hit and a stored insert.
    a_hit_acc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[1]))
        else $error("result flags both hit and accepted");

    // A committed hit advances the hit counter unless it is saturated.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && do_hit) |=>
            (hits_reg == $past(hits_reg) + 1'b1) || ($past(hits_reg) == TOT_MAX))
        else $error("hit counter did not advance on a hit");

endmodule

@@ tb/slot_cache_check_pkg.sv @@
// ---------------------------------------------------------------------------
// slot_cache_check_pkg
// Scoreboard for the keyed slot cache. It keeps its own copy of the tags,
// row counts, use stamps and counters, works out the reply to every accepted
// access and checks the replies of the block against them in order.
// ---------------------------------------------------------------------------
package slot_cache_check_pkg;

    import lkc_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic                  accepted;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [ROWS_W-1:0]     rows_held;
        logic [OCC_OUT_W-1:0]  occupied;
        logic [TOT_W-1:0]      hit_total;
        logic [TOT_W-1:0]      miss_total;
    } cache_reply_t;

    class cache_scoreboard;

        logic [KEY_W-1:0]   tag_high [SLOT_COUNT];
        logic [KEY_W-1:0]   tag_low [SLOT_COUNT];
        logic [ROWS_W-1:0]  slot_rows [SLOT_COUNT];
        logic [STAMP_W-1:0] use_stamp [SLOT_COUNT];
        logic [STAMP_W-1:0] use_clock;
        logic [TOT_W-1:0]   hit_count;
        logic [TOT_W-1:0]   miss_count;
        logic [ROWS_W-1:0]  row_limit;
        cache_reply_t       expected_replies [$];
        int                 mismatches;
        int                 replies_seen;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                tag_high[s]  = '0;
                tag_low[s]   = '0;
                slot_rows[s] = '0;
                use_stamp[s] = '0;
            end
            use_clock    = '0;
            hit_count    = '0;
            miss_count   = '0;
            row_limit    = ROW_LIMIT_RESET;
            mismatches   = 0;
            replies_seen = 0;
        endfunction

        function int find_slot(logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl);
            for (int s = 0; s < SLOT_COUNT; s++)
                if (slot_rows[s] != 0 && tag_high[s] == kh && tag_low[s] == kl)
                    return s;
            return -1;
        endfunction

        // Empty slots come first, then the oldest stamp; ties keep the lower index.
        function int pick_victim();
            int best;
            best = 0;
            for (int s = 1; s < SLOT_COUNT; s++)
            begin
                if ((slot_rows[s] == 0) != (slot_rows[best] == 0))
                begin
                    if (slot_rows[s] == 0)
                        best = s;
                end
                else if (use_stamp[s] < use_stamp[best])
                    best = s;
            end
            return best;
        endfunction

        function void predict_access(opcode_t op, logic [KEY_W-1:0] kh,
                                     logic [KEY_W-1:0] kl, logic [ROWS_W-1:0] rc);
            cache_reply_t r;
            int           s;
            int           occ;
            r = '0;
            if (op == OP_LOOKUP)
            begin
                s = find_slot(kh, kl);
                if (s >= 0)
                begin
                    use_clock    = use_clock + 1'b1;
                    use_stamp[s] = use_clock;
                    if (hit_count != TOT_MAX)
                        hit_count = hit_count + 1'b1;
                    r.hit        = 1'b1;
                    r.slot_index = SLOT_OUT_W'(s);
                    r.rows_held  = slot_rows[s];
                end
                else if (miss_count != TOT_MAX)
                    miss_count = miss_count + 1'b1;
            end
            else if (rc != 0 && rc <= row_limit)
            begin
                s = find_slot(kh, kl);
                if (s < 0)
                    s = pick_victim();
                tag_high[s]  = kh;
                tag_low[s]   = kl;
                slot_rows[s] = rc;
                use_clock    = use_clock + 1'b1;
                use_stamp[s] = use_clock;
                r.accepted   = 1'b1;
                r.slot_index = SLOT_OUT_W'(s);
            end
            occ = 0;
            for (int i = 0; i < SLOT_COUNT; i++)
                if (slot_rows[i] != 0)
                    occ++;
            r.occupied   = OCC_OUT_W'(occ);
            r.hit_total  = hit_count;
            r.miss_total = miss_count;
            expected_replies = {expected_replies, r};
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("reply %0d: %s is 0x%0h, expected 0x%0h", replies_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d);
            cache_reply_t got;
            cache_reply_t want;
            got.hit        = d[0];
            got.accepted   = d[1];
            got.slot_index = d[7:2];
            got.rows_held  = d[23:8];
            got.occupied   = d[30:24];
            got.hit_total  = d[62:31];
            got.miss_total = d[94:63];
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                report_mismatch("reply with no access outstanding", d[63:0], '0);
                return;
            end
            want = expected_replies.pop_front();
            if (got.hit !== want.hit)
                report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.accepted !== want.accepted)
                report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
            if (got.slot_index !== want.slot_index)
                report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
            if (got.rows_held !== want.rows_held)
                report_mismatch("rows_held", 64'(got.rows_held), 64'(want.rows_held));
            if (got.occupied !== want.occupied)
                report_mismatch("occupied", 64'(got.occupied), 64'(want.occupied));
            if (got.hit_total !== want.hit_total)
                report_mismatch("hit_total", 64'(got.hit_total), 64'(want.hit_total));
            if (got.miss_total !== want.miss_total)
                report_mismatch("miss_total", 64'(got.miss_total), 64'(want.miss_total));
        endtask

    endclass

endpackage

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Directed and random lookups and inserts through the keyed slot cache.
// Keys are drawn mostly from a small pool so that hits, in-place rewrites and
// LRU evictions are frequent; row_limit is swept through its extremes between
// phases, and both stream sides stall at random, once for a long stretch.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lkc_pkg::*;
    import slot_cache_check_pkg::*;

    localparam int POOL_SIZE    = 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [ROWS_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // key_high, key_low, row_count
    logic [0:0]             s_tuser;    // opcode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // hit, accepted, slot_index, rows_held,
                                        // occupied, hit_total, miss_total, pad

    cache_scoreboard   sb;
    logic [KEY_W-1:0]  pool_high [POOL_SIZE];
    logic [KEY_W-1:0]  pool_low [POOL_SIZE];
    logic [ROWS_W-1:0] row_limit_now;
    bit                sender_idle;
    bit                receiver_idle;
    bit                hold_off_req;
    int                cycle_count;

    lru_keyed_slot_cache u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [KEY_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Row counts within the limit, with zero, the limit, just above it, all ones and random values mixed in.
    function automatic logic [ROWS_W-1:0] pick_rows();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return row_limit_now;
        if (r < 24)
            return (row_limit_now == '1) ? row_limit_now : row_limit_now + 1'b1;
        if (r < 34)
            return '1;
        if (r < 70)
            return ROWS_W'($urandom_range(1, (row_limit_now == 0) ? 1 : row_limit_now));
        return ROWS_W'($urandom_range(0, 65535));
    endfunction

    // Some neighboring pool keys share one half so that a match must check both; some share both halves.
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_high[i] = (i % 2 == 1) ? pool_high[i-1] : random_word();
            pool_low[i]  = (i % 3 == 2) ? pool_low[i-1] : random_word();
        end
    endtask

    task automatic send_access(input opcode_t op, input logic [KEY_W-1:0] kh,
                               input logic [KEY_W-1:0] kl, input logic [ROWS_W-1:0] rc);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rc, kl, kh};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.predict_access(op, kh, kl, rc);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_limit(input logic [ROWS_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.row_limit  = value;
        row_limit_now = value;
    endtask

    task automatic run_random(input int count);
        opcode_t          op;
        int               p;
        logic [KEY_W-1:0] kh;
        logic [KEY_W-1:0] kl;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                sender_idle   = ($urandom_range(0, 3) != 0);
                receiver_idle = ($urandom_range(0, 3) != 0);
            end
            op = ($urandom_range(0, 99) < 55) ? OP_LOOKUP : OP_INSERT;
            if ($urandom_range(0, 99) < 80)
            begin
                p  = $urandom_range(0, POOL_SIZE - 1);
                kh = pool_high[p];
                kl = pool_low[p];
            end
            else
            begin
                kh = random_word();
                kl = random_word();
            end
            send_access(op, kh, kl, pick_rows());
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = ROW_LIMIT_RESET;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_LOOKUP;
        row_limit_now = ROW_LIMIT_RESET;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        hold_off_req  = 1'b0;
        refresh_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The scoreboard starts with zero tags, so the zero key must still miss on an empty cache.
        send_access(OP_LOOKUP, '0, '0, '1);
        send_access(OP_INSERT, '0, '0, '0);
        send_access(OP_INSERT, '0, '0, 16'd1);
        send_access(OP_LOOKUP, '0, '0, '0);
        send_access(OP_INSERT, '1, '1, '1);
        send_access(OP_LOOKUP, '1, '1, '0);
        send_access(OP_INSERT, '1, '1, 16'd7);
        send_access(OP_LOOKUP, '1, '0, '0);
        // Seven inserts fill the cache: pool key 5 equals key 4 and is rewritten in place, so the zero key stays.
        for (int i = 0; i < 7; i++)
            send_access(OP_INSERT, pool_high[i], pool_low[i], ROWS_W'(i + 2));
        send_access(OP_LOOKUP, '0, '0, '0);
        send_access(OP_LOOKUP, pool_high[0], pool_low[0], '0);
        send_access(OP_INSERT, {32{2'b10}}, {32{2'b01}}, 16'h8000);
        stop_and_drain();
        write_row_limit(16'd1);
        send_access(OP_INSERT, pool_high[1], pool_low[1], 16'd2);
        send_access(OP_INSERT, pool_high[1], pool_low[1], 16'd1);
        stop_and_drain();
        write_row_limit('0);
        send_access(OP_INSERT, pool_high[2], pool_low[2], 16'd1);
        send_access(OP_LOOKUP, pool_high[1], pool_low[1], '0);
        stop_and_drain();

        write_row_limit('1);
        run_random(100);
        stop_and_drain();
        write_row_limit(ROWS_W'($urandom_range(2, 65534)));
        refresh_pool();
        // The receiver stalls long enough for the input side to back up.
        hold_off_req = 1'b1;
        run_random(90);
        stop_and_drain();
        write_row_limit(16'd1);
        run_random(70);
        stop_and_drain();
        write_row_limit(16'd300);
        refresh_pool();
        run_random(90);
        stop_and_drain();
        write_row_limit('0);
        run_random(30);
        stop_and_drain();
        write_row_limit('1);
        refresh_pool();
        run_random(120);
        stop_and_drain();

        if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall        = HOLD_CYCLES;
            end
            else
                stall = receiver_idle ? pick_gap() : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
